// File: rtl/core/shuffle_bag_draw_core_defines.svh
// ----------------------------------------------------------------------------
// shuffle bag draw core assertion macros
// concurrent check helpers shared by the rtl files of the draw core
// ----------------------------------------------------------------------------
`ifndef SHUFFLE_BAG_DRAW_CORE_DEFINES_SVH
`define SHUFFLE_BAG_DRAW_CORE_DEFINES_SVH

// same-cycle implication
`define SBD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sbd check failed");

// next-cycle implication
`define SBD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sbd check failed");

`endif

// File: rtl/core/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg
// shared widths, constants, state codes and generator step of the draw core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbd_pkg;

    localparam int IDX_W         = 5;
    localparam int CFG_W         = 6;
    localparam int GEN_W         = 32;
    localparam int MAX_ITEMS_DEF = 32;
    localparam int STEP_BITS     = 8;
    localparam int MOD_STEPS     = GEN_W / STEP_BITS;

    localparam logic [GEN_W-1:0] GEN_RESET   = 32'h0005_1A17;
    localparam logic [CFG_W-1:0] COUNT_RESET = 6'd15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_GEN,
        ST_MOD,
        ST_SWRD,
        ST_SWWR_I,
        ST_SWWR_J,
        ST_FIXRD,
        ST_FIXCHK,
        ST_FIXWR,
        ST_DRAWRD,
        ST_DRAWOUT
    } sbd_state_t;

    function automatic logic [GEN_W-1:0] xorshift_step(input logic [GEN_W-1:0] g);
        logic [GEN_W-1:0] x1;
        logic [GEN_W-1:0] x2;
        x1 = g ^ (g << 13);
        x2 = x1 ^ (x1 >> 17);
        return x2 ^ (x2 << 5);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sbd_bag_ram.sv
// ----------------------------------------------------------------------------
// sbd_bag_ram
// bag entry memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbd_bag_ram #(
    parameter int DEPTH = sbd_pkg::MAX_ITEMS_DEF
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [sbd_pkg::IDX_W-1:0]    wdata,
    input  logic [$clog2(DEPTH)-1:0]     raddr_a,
    input  logic [$clog2(DEPTH)-1:0]     raddr_b,
    output logic [sbd_pkg::IDX_W-1:0]    rdata_a,
    output logic [sbd_pkg::IDX_W-1:0]    rdata_b
);

    import sbd_pkg::*;

    logic [IDX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// File: rtl/core/sbd_mod_unit.sv
// ----------------------------------------------------------------------------
// sbd_mod_unit
// iterative remainder of a 32-bit value by a small divisor, one byte a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbd_mod_unit #(
    parameter int DIV_W = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sbd_pkg::GEN_W-1:0] dividend,
    input  logic [DIV_W-1:0]          divisor,
    output logic                      done,
    output logic [DIV_W-1:0]          rem
);

    import sbd_pkg::*;

    localparam int CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [GEN_W-1:0] dvd_reg;
    logic [GEN_W-1:0] dvd_next;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W-1:0] dvs_next;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W-1:0] rem_step;

    // restoring remainder over the top byte of the shifting dividend
    always_comb
    begin
        logic [DIV_W:0]   t;
        logic [DIV_W-1:0] r;
        r = rem_reg;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            t = {r, dvd_reg[GEN_W-1-k]};
            if (t >= {1'b0, dvs_reg})
            begin
                r = DIV_W'(t - {1'b0, dvs_reg});
            end
            else
            begin
                r = t[DIV_W-1:0];
            end
        end
        rem_step = r;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            dvd_next = dvd_reg << STEP_BITS;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// File: rtl/core/shuffle_bag_draw_core.sv
// ----------------------------------------------------------------------------
// shuffle_bag_draw_core
// shuffle bag draw: refill, fisher-yates shuffle with xorshift32, draw
//
// channel   ports                          handshake
// draw in   start, restart                 taken when start and not busy
// draw out  done, drawn_index, reshuffled  one-cycle strobe, no back-pressure
// config    item_count_we, item_count      written on any edge with we high
//
// a draw from a filled bag reads the entry and registers it as the result; a
// refilling draw writes the n entries, runs one swap per position from n-1
// down to 1, then the last-index fix (neither for a single entry); each swap
// is a generator step, the byte-per-cycle remainder unit, one read, two writes
// busy drops with the result strobe; the next item can be taken at its end
// reset clears the bag state at once, no clearing pass; results cannot stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shuffle_bag_draw_core #(
    parameter int MAX_ITEMS = sbd_pkg::MAX_ITEMS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      restart,
    output logic                      done,
    output logic [sbd_pkg::IDX_W-1:0] drawn_index,
    output logic                      reshuffled,
    input  logic                      item_count_we,
    input  logic [sbd_pkg::CFG_W-1:0] item_count
);

    import sbd_pkg::*;

    `include "shuffle_bag_draw_core_defines.svh"

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    sbd_state_t        state_reg;
    sbd_state_t        state_next;
    logic [CFG_W-1:0]  count_reg;
    logic [CFG_W-1:0]  count_next;
    logic [GEN_W-1:0]  gen_reg;
    logic [GEN_W-1:0]  gen_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [CNT_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  pos_next;
    logic [IDX_W-1:0]  last_reg;
    logic [IDX_W-1:0]  last_next;
    logic              last_valid_reg;
    logic              last_valid_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  n_next;
    logic [ADDR_W-1:0] i_reg;
    logic [ADDR_W-1:0] i_next;
    logic [ADDR_W-1:0] j_reg;
    logic [ADDR_W-1:0] j_next;
    logic [IDX_W-1:0]  tmp_reg;
    logic [IDX_W-1:0]  tmp_next;
    logic              reshuf_reg;
    logic              reshuf_next;
    logic [IDX_W-1:0]  drawn_reg;
    logic [IDX_W-1:0]  drawn_next;
    logic              reshuf_out_reg;
    logic              reshuf_out_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [IDX_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr_a;
    logic [ADDR_W-1:0] ram_raddr_b;
    logic [IDX_W-1:0]  ram_rdata_a;
    logic [IDX_W-1:0]  ram_rdata_b;

    logic              mod_start;
    logic              mod_done;
    logic [CNT_W-1:0]  mod_rem;
    logic [GEN_W-1:0]  gen_step;
    logic [CMP_W-1:0]  count_ext;
    logic [CNT_W-1:0]  n_eff;

    sbd_bag_ram #(
        .DEPTH(MAX_ITEMS)
    ) u_bag_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    sbd_mod_unit #(
        .DIV_W(CNT_W)
    ) u_mod_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (gen_step),
        .divisor  (CNT_W'(i_reg) + CNT_W'(1)),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign gen_step  = xorshift_step(gen_reg);
    assign count_ext = CMP_W'(count_reg);

    // zero counts as one, saturate at the bag depth
    always_comb
    begin
        if (count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (count_ext > CMP_W'(MAX_ITEMS))
        begin
            n_eff = CNT_W'(MAX_ITEMS);
        end
        else
        begin
            n_eff = CNT_W'(count_ext);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = item_count_we ? item_count : count_reg;
        gen_next        = gen_reg;
        fill_next       = fill_reg;
        pos_next        = pos_reg;
        last_next       = last_reg;
        last_valid_next = last_valid_reg;
        done_next       = 1'b0;
        n_next          = n_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        tmp_next        = tmp_reg;
        reshuf_next     = reshuf_reg;
        drawn_next      = drawn_reg;
        reshuf_out_next = reshuf_out_reg;
        ram_we          = 1'b0;
        ram_waddr       = i_reg;
        ram_wdata       = IDX_W'(i_reg);
        ram_raddr_a     = i_reg;
        ram_raddr_b     = j_reg;
        mod_start       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (restart)
                    begin
                        last_valid_next = 1'b0;
                    end
                    if (restart || (pos_reg >= fill_reg))
                    begin
                        n_next      = n_eff;
                        fill_next   = n_eff;
                        pos_next    = '0;
                        i_next      = '0;
                        reshuf_next = 1'b1;
                        state_next  = ST_FILL;
                    end
                    else
                    begin
                        reshuf_next = 1'b0;
                        state_next  = ST_DRAWRD;
                    end
                end
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = IDX_W'(i_reg);
                if (CNT_W'(i_reg) == n_reg - CNT_W'(1))
                begin
                    if (n_reg == CNT_W'(1))
                    begin
                        state_next = ST_DRAWRD;
                    end
                    else
                    begin
                        i_next     = ADDR_W'(n_reg - CNT_W'(1));
                        state_next = ST_GEN;
                    end
                end
                else
                begin
                    i_next = i_reg + ADDR_W'(1);
                end
            end
            ST_GEN:
            begin
                gen_next   = gen_step;
                mod_start  = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    j_next     = mod_rem[ADDR_W-1:0];
                    state_next = ST_SWRD;
                end
            end
            ST_SWRD:
            begin
                ram_raddr_a = i_reg;
                ram_raddr_b = j_reg;
                state_next  = ST_SWWR_I;
            end
            ST_SWWR_I:
            begin
                ram_we     = 1'b1;
                ram_waddr  = i_reg;
                ram_wdata  = ram_rdata_b;
                tmp_next   = ram_rdata_a;
                state_next = ST_SWWR_J;
            end
            ST_SWWR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = tmp_reg;
                if (i_reg == ADDR_W'(1))
                begin
                    state_next = ST_FIXRD;
                end
                else
                begin
                    i_next     = i_reg - ADDR_W'(1);
                    state_next = ST_GEN;
                end
            end
            ST_FIXRD:
            begin
                ram_raddr_a = '0;
                ram_raddr_b = ADDR_W'(1);
                state_next  = ST_FIXCHK;
            end
            ST_FIXCHK:
            begin
                // avoid repeating the last drawn index across bags
                if (last_valid_reg && (ram_rdata_a == last_reg))
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = ram_rdata_b;
                    tmp_next   = ram_rdata_a;
                    state_next = ST_FIXWR;
                end
                else
                begin
                    state_next = ST_DRAWRD;
                end
            end
            ST_FIXWR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ADDR_W'(1);
                ram_wdata  = tmp_reg;
                state_next = ST_DRAWRD;
            end
            ST_DRAWRD:
            begin
                ram_raddr_a = pos_reg[ADDR_W-1:0];
                state_next  = ST_DRAWOUT;
            end
            ST_DRAWOUT:
            begin
                drawn_next      = ram_rdata_a;
                reshuf_out_next = reshuf_reg;
                done_next       = 1'b1;
                last_next       = ram_rdata_a;
                last_valid_next = 1'b1;
                pos_next        = pos_reg + CNT_W'(1);
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= COUNT_RESET;
            gen_reg        <= GEN_RESET;
            fill_reg       <= '0;
            pos_reg        <= '0;
            last_reg       <= '0;
            last_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            gen_reg        <= gen_next;
            fill_reg       <= fill_next;
            pos_reg        <= pos_next;
            last_reg       <= last_next;
            last_valid_reg <= last_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        tmp_reg        <= tmp_next;
        reshuf_reg     <= reshuf_next;
        drawn_reg      <= drawn_next;
        reshuf_out_reg <= reshuf_out_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign drawn_index = drawn_reg;
    assign reshuffled  = reshuf_out_reg;

    `SBD_ASSERT_NOW(a_done_idle, clk, rst_n, done_reg, state_reg == ST_IDLE)
    `SBD_ASSERT_NEXT(a_restart_fill, clk, rst_n, start && !busy && restart, state_reg == ST_FILL)
    `SBD_ASSERT_NOW(a_pos_bound, clk, rst_n, 1'b1, pos_reg <= fill_reg)
    `SBD_ASSERT_NOW(a_swap_order, clk, rst_n, state_reg == ST_SWRD, j_reg <= i_reg)
    `SBD_ASSERT_NOW(a_write_bound, clk, rst_n, ram_we, CNT_W'(ram_waddr) < n_reg)

endmodule

`default_nettype wire
